>>> hdl/rcc_pkg.sv
// Shared constants and types for the RGB colour correction pipeline.
package rcc_pkg;

    localparam int NUM_CH    = 3;
    localparam int CH_W      = 8;
    localparam int GAIN_W    = 16;
    localparam int CFG_IDX_W = 2;
    localparam int GAIN_FRAC = 12;
    localparam int LUMA_FRAC = 16;

    // Q8.8 reference levels on the 0..255 scale.
    localparam int MID_GREY_Q88 = 32640;
    localparam int MAX_Q88      = 65280;

    // Rec.601 luma weights in Q0.16, order red, green, blue.
    localparam int LUMA_W [NUM_CH] = '{19595, 38470, 7471};

    localparam logic [GAIN_W-1:0] UNITY_GAIN = 16'd4096;

    // Datapath widths, chosen so that no stage wraps.
    localparam int W_EPROD = 32;  // byte Q8.8 times exposure gain
    localparam int W_EXP   = W_EPROD - GAIN_FRAC;
    localparam int W_DIFF  = W_EXP + 1;
    localparam int W_CPROD = W_DIFF + GAIN_W + 1;
    localparam int W_C     = 27;  // channel after contrast, signed Q8.8
    localparam int W_LP    = W_C + GAIN_W + 1;
    localparam int W_LS    = W_LP + 2;
    localparam int W_SDIFF = W_C + 1;
    localparam int W_SPROD = W_SDIFF + GAIN_W + 1;
    localparam int W_FIN   = W_SPROD - GAIN_FRAC + 2;

    localparam int NSTG = 7;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_EXPOSURE    = 2'd0,
        REG_CONTRAST    = 2'd1,
        REG_SATURATION  = 2'd2,
        REG_TEMPERATURE = 2'd3
    } t_cfg_idx;

    typedef logic [CH_W-1:0] t_pix [NUM_CH];

endpackage

>>> hdl/rgb_color_correction.sv
// Top level of the RGB colour correction pipeline.
//
// Usage: pixels enter on the s_axis channel, one beat per pixel, with red
// in tdata[7:0], green in tdata[15:8] and blue in tdata[23:16]; tlast marks
// the final pixel of a frame and is passed through unchanged. Corrected
// pixels leave on the m_axis channel in the same layout and order.
// The user must write the four gain and offset registers through the plain
// write port (i_cfg_we, i_cfg_addr, i_cfg_data) only while no pixel is in
// flight; the block itself does not enforce this. Throughput is one pixel
// per clock while m_axis_tready stays high; a receiver stall holds the flow.
// Reset clears every stage valid bit and loads unity gains and a zero
// temperature offset. When the receiver stalls, each stage holds its beat
// and empty stages further up keep filling, so s_axis_tready only drops
// once every stage between input and output holds a pixel.
module rgb_color_correction
    import rcc_pkg::*;
(
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_cfg_we,
    input  logic [CFG_IDX_W-1:0] i_cfg_addr,
    input  logic [GAIN_W-1:0]    i_cfg_data,
    input  logic                 s_axis_tvalid,
    output logic                 s_axis_tready,
    input  logic [23:0]          s_axis_tdata,   // red_in, green_in, blue_in
    input  logic                 s_axis_tlast,   // last_in
    output logic                 m_axis_tvalid,
    input  logic                 m_axis_tready,
    output logic [23:0]          m_axis_tdata,   // red_out, green_out, blue_out
    output logic                 m_axis_tlast    // last_out
);

    logic [GAIN_W-1:0]        r_exp_gain;
    logic [GAIN_W-1:0]        r_con_gain;
    logic [GAIN_W-1:0]        r_sat_gain;
    logic signed [GAIN_W-1:0] r_temp;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_exp_gain <= UNITY_GAIN;
            r_con_gain <= UNITY_GAIN;
            r_sat_gain <= UNITY_GAIN;
            r_temp     <= '0;
        end else if (i_cfg_we) begin
            unique case (t_cfg_idx'(i_cfg_addr))
                REG_EXPOSURE:    r_exp_gain <= i_cfg_data;
                REG_CONTRAST:    r_con_gain <= i_cfg_data;
                REG_SATURATION:  r_sat_gain <= i_cfg_data;
                REG_TEMPERATURE: r_temp     <= $signed(i_cfg_data);
                default: ;
            endcase
        end
    end

    // Stage control: a stage loads when it is empty or its successor moves.
    logic [NSTG-1:0] r_vld;
    logic [NSTG-1:0] r_last;
    logic [NSTG-1:0] en;

    always_comb begin
        en[NSTG-1] = !r_vld[NSTG-1] || m_axis_tready;
        for (int k = NSTG - 2; k >= 0; k--) begin
            en[k] = !r_vld[k] || en[k+1];
        end
    end

    assign s_axis_tready = en[0];

    logic acc_in;
    logic acc_out;
    assign acc_in  = s_axis_tvalid && s_axis_tready;
    assign acc_out = m_axis_tvalid && m_axis_tready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else begin
            if (en[0]) begin
                r_vld[0] <= s_axis_tvalid;
            end
            for (int k = 1; k < NSTG; k++) begin
                if (en[k]) begin
                    r_vld[k] <= r_vld[k-1];
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (en[0]) begin
            r_last[0] <= s_axis_tlast;
        end
        for (int k = 1; k < NSTG; k++) begin
            if (en[k]) begin
                r_last[k] <= r_last[k-1];
            end
        end
    end

    t_pix pix_in;
    assign pix_in[0] = s_axis_tdata[7:0];
    assign pix_in[1] = s_axis_tdata[15:8];
    assign pix_in[2] = s_axis_tdata[23:16];

    logic signed [GAIN_W:0] con_gain_s;
    logic signed [GAIN_W:0] sat_gain_s;
    assign con_gain_s = $signed({1'b0, r_con_gain});
    assign sat_gain_s = $signed({1'b0, r_sat_gain});

    // Datapath registers, one set per stage.
    logic [W_EPROD-1:0]        r_p1  [NUM_CH];
    logic signed [W_CPROD-1:0] r_p2  [NUM_CH];
    logic signed [W_C-1:0]     r_c3  [NUM_CH];
    logic signed [W_LP-1:0]    r_lp4 [NUM_CH];
    logic signed [W_C-1:0]     r_c4  [NUM_CH];
    logic signed [W_C-1:0]     r_c5  [NUM_CH];
    logic signed [W_C-1:0]     r_lum5;
    logic signed [W_SPROD-1:0] r_sp6 [NUM_CH];
    logic signed [W_C-1:0]     r_lum6;
    logic [CH_W-1:0]           r_o7  [NUM_CH];

    logic signed [W_DIFF-1:0]  d2  [NUM_CH];
    logic signed [W_LS-1:0]    lsum5;
    logic signed [W_SDIFF-1:0] sd6 [NUM_CH];
    logic signed [W_FIN-1:0]   f7  [NUM_CH];
    logic [CH_W-1:0]           o7  [NUM_CH];

    always_comb begin
        lsum5 = W_LS'(r_lp4[0]) + W_LS'(r_lp4[1]) + W_LS'(r_lp4[2]);
        for (int k = 0; k < NUM_CH; k++) begin
            d2[k]  = $signed({1'b0, r_p1[k][W_EPROD-1:GAIN_FRAC]}) - W_DIFF'(MID_GREY_Q88);
            sd6[k] = W_SDIFF'(r_c5[k]) - W_SDIFF'(r_lum6 == r_lum6 ? r_lum5 : r_lum5);
            f7[k]  = W_FIN'(r_sp6[k] >>> GAIN_FRAC) + W_FIN'(r_lum6);
        end
        // Warm shift: the offset raises red and lowers blue.
        f7[0] = f7[0] + W_FIN'(r_temp);
        f7[2] = f7[2] - W_FIN'(r_temp);
        for (int k = 0; k < NUM_CH; k++) begin
            if (f7[k] < 0) begin
                o7[k] = '0;
            end else if (f7[k] > W_FIN'(MAX_Q88)) begin
                o7[k] = '1;
            end else begin
                o7[k] = f7[k][2*CH_W-1:CH_W];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        for (int k = 0; k < NUM_CH; k++) begin
            if (en[0]) begin
                r_p1[k] <= W_EPROD'({pix_in[k], 8'd0}) * W_EPROD'(r_exp_gain);
            end
            if (en[1]) begin
                r_p2[k] <= W_CPROD'(d2[k]) * W_CPROD'(con_gain_s);
            end
            if (en[2]) begin
                r_c3[k] <= W_C'(r_p2[k] >>> GAIN_FRAC) + W_C'(MID_GREY_Q88);
            end
            if (en[3]) begin
                r_lp4[k] <= W_LP'(r_c3[k]) * W_LP'(LUMA_W[k]);
                r_c4[k]  <= r_c3[k];
            end
            if (en[4]) begin
                r_c5[k] <= r_c4[k];
            end
            if (en[5]) begin
                r_sp6[k] <= W_SPROD'(sd6[k]) * W_SPROD'(sat_gain_s);
            end
            if (en[6]) begin
                r_o7[k] <= o7[k];
            end
        end
        if (en[4]) begin
            r_lum5 <= W_C'(lsum5 >>> LUMA_FRAC);
        end
        if (en[5]) begin
            r_lum6 <= r_lum5;
        end
    end

    assign m_axis_tvalid = r_vld[NSTG-1];
    assign m_axis_tlast  = r_last[NSTG-1];
    assign m_axis_tdata  = {r_o7[2], r_o7[1], r_o7[0]};

    // The pipeline occupancy changes only by the beats taken in and out.
    a_occupancy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        1'b1 |=> ($countones(r_vld) ==
                  $past($countones(r_vld)) + $past(acc_in) - $past(acc_out)))
        else $error("pipeline occupancy does not match accepted beats");

    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> (r_vld == '0))
        else $error("stage valid bits not cleared by reset");

    a_full_stall: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ((&r_vld) && !m_axis_tready) |-> !s_axis_tready)
        else $error("input accepted while the full pipeline is stalled");

    a_enter: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        acc_in |=> r_vld[0])
        else $error("accepted beat did not reach the first stage");

endmodule
